@@ rtl/hpcd_pkg.sv @@
`timescale 1ns / 1ps

package hpcd_pkg;

    // sizes
    localparam int SAMPLE_BITS    = 12;
    localparam int HIGH_CODE_BITS = 8;
    localparam int MARGIN_W       = 10;
    localparam int CNT_W          = 4;
    localparam int TOT_W          = 8;
    localparam int LOW_W          = 3;
    localparam int HIGH_W         = 8;
    localparam int HIDX_W         = $clog2(HIGH_W);
    localparam int PHASE_W        = 2;

    // only the low HIGH_W bits of the high code are ever visible
    localparam int HIGH_KEEP = (HIGH_CODE_BITS < HIGH_W) ? HIGH_CODE_BITS : HIGH_W;

    // sum widths for threshold compares
    localparam int WIDE_W = (SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W;
    localparam int SUM_W  = WIDE_W + 1;
    localparam int ZERO_W = SAMPLE_BITS + 1;
    localparam int BIT_W  = ((ZERO_W > MARGIN_W) ? ZERO_W : MARGIN_W) + 1;

    // x/25 as (x * DIV25_MUL) >> DIV25_SHIFT, exact for x below 2**16
    localparam int DIV25_MUL   = 83887;
    localparam int DIV25_MUL_W = 17;
    localparam int DIV25_SHIFT = 21;
    localparam int DIV25_PROD_W = SAMPLE_BITS + DIV25_MUL_W;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = WIDE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_HEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BELT_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MARGIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_MARGIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARGIN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MARGIN = 3'd6;

    // reset values
    localparam int ITEM_RST   = 2500;
    localparam int BELT_RST   = 3600;
    localparam int EXP_RST    = 10;
    localparam int MARGIN_RST = 100;
    localparam int ZERO_RST   = ITEM_RST + (ITEM_RST / 25) * 2;

    // phase codes
    localparam logic [PHASE_W-1:0] PH_SPACE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_EDGE  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FINAL = 2'd2;
    localparam logic [PHASE_W-1:0] PH_STOP  = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] height;
        logic                   start_req;
        logic                   abort;
    } t_in_word;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               done_res;
        logic [LOW_W-1:0]   low_code;
        logic [HIGH_W-1:0]  high_code;
        logic [TOT_W-1:0]   edges_seen;
        logic [TOT_W-1:0]   spaces_seen;
    } t_out_word;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] item_height;
        logic [SAMPLE_BITS-1:0] belt_height;
        logic [CNT_W-1:0]       expected;
        logic [MARGIN_W-1:0]    edge_margin;
        logic [MARGIN_W-1:0]    space_margin;
        logic [MARGIN_W-1:0]    bit_margin;
        logic [MARGIN_W-1:0]    final_margin;
        logic [ZERO_W-1:0]      zero_level;
    } t_cfg;

endpackage

@@ rtl/hpcd_in_if.sv @@
`timescale 1ns / 1ps

interface hpcd_in_if
    import hpcd_pkg::*;
;
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hpcd_out_if.sv @@
`timescale 1ns / 1ps

interface hpcd_out_if
    import hpcd_pkg::*;
;
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/hpcd_cfg.sv @@
`timescale 1ns / 1ps

module hpcd_cfg
    import hpcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg                    r_cfg;
    logic [SAMPLE_BITS-1:0]  w_item;
    logic [DIV25_PROD_W-1:0] w_prod;
    logic [SAMPLE_BITS-1:0]  w_quot;
    logic [ZERO_W-1:0]       w_zero;

    // zero level = item + 2 * (item / 25), worked out when item height is written
    always_comb begin
        w_item = i_cfg_data[SAMPLE_BITS-1:0];
        w_prod = DIV25_PROD_W'(w_item) * DIV25_PROD_W'(DIV25_MUL);
        w_quot = SAMPLE_BITS'(w_prod >> DIV25_SHIFT);
        w_zero = ZERO_W'(w_item) + (ZERO_W'(w_quot) << 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.item_height  <= SAMPLE_BITS'(ITEM_RST);
            r_cfg.belt_height  <= SAMPLE_BITS'(BELT_RST);
            r_cfg.expected     <= CNT_W'(EXP_RST);
            r_cfg.edge_margin  <= MARGIN_W'(MARGIN_RST);
            r_cfg.space_margin <= MARGIN_W'(MARGIN_RST);
            r_cfg.bit_margin   <= MARGIN_W'(MARGIN_RST);
            r_cfg.final_margin <= MARGIN_W'(MARGIN_RST);
            r_cfg.zero_level   <= ZERO_W'(ZERO_RST);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ITEM_HEIGHT: begin
                    r_cfg.item_height <= w_item;
                    r_cfg.zero_level  <= w_zero;
                end
                CFG_BELT_HEIGHT:  r_cfg.belt_height  <= i_cfg_data[SAMPLE_BITS-1:0];
                CFG_EXPECTED:     r_cfg.expected     <= i_cfg_data[CNT_W-1:0];
                CFG_EDGE_MARGIN:  r_cfg.edge_margin  <= i_cfg_data[MARGIN_W-1:0];
                CFG_SPACE_MARGIN: r_cfg.space_margin <= i_cfg_data[MARGIN_W-1:0];
                CFG_BIT_MARGIN:   r_cfg.bit_margin   <= i_cfg_data[MARGIN_W-1:0];
                CFG_FINAL_MARGIN: r_cfg.final_margin <= i_cfg_data[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/hpcd_core.sv @@
`timescale 1ns / 1ps

module hpcd_core
    import hpcd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    hpcd_in_if.sink           i_in,
    hpcd_out_if.source        o_out
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [TOT_W-1:0]   r_edges, n_edges;
    logic [TOT_W-1:0]   r_spaces, n_spaces;
    logic [LOW_W-1:0]   r_low, n_low;
    logic [HIGH_W-1:0]  r_high, n_high;
    logic               n_done;
    logic               r_out_valid;
    t_out_word          r_out;

    logic                   w_acc;
    logic [SAMPLE_BITS-1:0] w_h;
    logic [PHASE_W-1:0]     w_ph;
    logic [CNT_W-1:0]       w_cnt;
    logic                   w_space_q;
    logic                   w_edge_q;
    logic                   w_stay;
    logic                   w_bit;
    logic [TOT_W-1:0]       w_hidx;

    function automatic logic [CNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        sat_cnt = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [TOT_W-1:0] sat_tot(input logic [TOT_W-1:0] v);
        sat_tot = (v == {TOT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_h        = i_in.data.height;

    // sample qualification and code bit
    always_comb begin
        w_space_q = SUM_W'(w_h) <= SUM_W'(i_cfg.item_height) + SUM_W'(i_cfg.edge_margin);
        w_edge_q  = SUM_W'(w_h) >= SUM_W'(i_cfg.item_height) + SUM_W'(i_cfg.space_margin);
        w_stay    = SUM_W'(w_h) + SUM_W'(i_cfg.final_margin) <= SUM_W'(i_cfg.belt_height);
        w_bit     = BIT_W'(w_h) > BIT_W'(i_cfg.zero_level) + BIT_W'(i_cfg.bit_margin);
    end

    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_edges  = r_edges;
        n_spaces = r_spaces;
        n_low    = r_low;
        n_high   = r_high;
        n_done   = 1'b0;
        w_ph     = r_phase;
        w_cnt    = r_cnt;
        w_hidx   = '0;
        if (i_in.data.abort) begin
            n_phase = PH_STOP;
        end else begin
            if (i_in.data.start_req) begin
                w_ph     = PH_SPACE;
                n_phase  = PH_SPACE;
                n_cnt    = '0;
                n_edges  = '0;
                n_spaces = '0;
                n_low    = '0;
                n_high   = '0;
            end
            unique case (w_ph)
                PH_SPACE: begin
                    w_cnt = w_space_q ? sat_cnt(n_cnt) : n_cnt;
                    if (w_cnt >= i_cfg.expected) begin
                        n_phase = PH_EDGE;
                        n_cnt   = '0;
                        n_edges = sat_tot(n_edges);
                    end else begin
                        n_cnt = w_cnt;
                    end
                end
                PH_EDGE: begin
                    w_cnt = w_edge_q ? sat_cnt(n_cnt) : n_cnt;
                    if (w_cnt >= i_cfg.expected) begin
                        n_phase  = w_stay ? PH_SPACE : PH_FINAL;
                        n_cnt    = '0;
                        n_spaces = sat_tot(n_spaces);
                        w_hidx   = n_spaces - TOT_W'(4);
                        // the first LOW_W edge ends feed the low code
                        if (n_spaces >= TOT_W'(1) && n_spaces <= TOT_W'(3)) begin
                            n_low = n_low | (LOW_W'(w_bit) << (n_spaces[1:0] - 2'd1));
                        end else if (n_spaces >= TOT_W'(4) && w_hidx < TOT_W'(HIGH_KEEP)) begin
                            n_high = n_high | (HIGH_W'(w_bit) << w_hidx[HIDX_W-1:0]);
                        end
                    end else begin
                        n_cnt = w_cnt;
                    end
                end
                PH_FINAL: begin
                    n_phase = PH_STOP;
                    n_done  = 1'b1;
                end
                PH_STOP: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_STOP;
            r_cnt       <= '0;
            r_edges     <= '0;
            r_spaces    <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_edges     <= n_edges;
            r_spaces    <= n_spaces;
            r_low       <= n_low;
            r_high      <= n_high;
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_out.phase       <= n_phase;
            r_out.done_res    <= n_done;
            r_out.low_code    <= n_low;
            r_out.high_code   <= n_high;
            r_out.edges_seen  <= n_edges;
            r_out.spaces_seen <= n_spaces;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.done_res |-> r_out.phase == PH_STOP)
        else $error("done word without stopped phase");

    a_abort_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && i_in.data.abort |=> r_phase == PH_STOP && !r_out.done_res)
        else $error("abort did not stop the block");

    a_final_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_in.data.abort && !i_in.data.start_req && r_phase == PH_FINAL
        |=> r_out.done_res && r_phase == PH_STOP)
        else $error("final phase did not finish");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_in.data.abort && i_in.data.start_req
        |=> r_spaces == '0 && r_low == '0 && r_high == '0 && r_edges <= TOT_W'(1))
        else $error("start did not clear the measurement");

    a_spaces_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !i_in.data.start_req |=> r_spaces >= $past(r_spaces))
        else $error("edge end count went down");

endmodule

@@ rtl/height_profile_code_decoder_top.sv @@
`timescale 1ns / 1ps

// channel   | dir | handshake         | word
// ----------+-----+-------------------+----------------------------------------------
// i_in      | in  | valid / ready     | height, start_req, abort
// o_out     | out | valid / ready     | phase, done_res, low_code, high_code,
//           |     |                   | edges_seen, spaces_seen
// cfg write | in  | i_cfg_we (no wait)| i_cfg_idx selects register, i_cfg_data value
//
// one word in per cycle while ready, one result word per input word, valid the cycle after accept
// the whole per-sample update is combinational compares and saturating counters
// reset is synchronous, active low: phase stopped, counts and codes cleared, registers at defaults
// i_in.ready drops only while a result word is held and o_out.ready is low
// config writes are assumed only while no word is in flight

module height_profile_code_decoder_top
    import hpcd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    hpcd_in_if.sink               i_in,
    hpcd_out_if.source            o_out
);

    // live register set, zero level for the bit decision is kept precomputed
    t_cfg w_cfg;

    hpcd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // phase tracking, code bit capture and the result word register
    hpcd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

@@ verif/height_profile_code_decoder_top_test.sv @@
`timescale 1ns / 1ps

module height_profile_code_decoder_top_test
    import hpcd_pkg::*;
;

    localparam int MAX_HEIGHT   = (1 << SAMPLE_BITS) - 1;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_WORDS = 40;
    localparam int HOLD_CYCLES  = 80;

    // calibration as the decoder holds it, at register widths
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] item;
        logic [SAMPLE_BITS-1:0] belt;
        logic [CNT_W-1:0]       expected;
        logic [MARGIN_W-1:0]    edge_m;
        logic [MARGIN_W-1:0]    space_m;
        logic [MARGIN_W-1:0]    bit_m;
        logic [MARGIN_W-1:0]    final_m;
    } t_calib;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    hpcd_in_if  in_if ();
    hpcd_out_if out_if ();

    height_profile_code_decoder_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // decoder copy: calibration starts at the reset defaults
    t_calib cal = '{item: SAMPLE_BITS'(ITEM_RST), belt: SAMPLE_BITS'(BELT_RST),
                    expected: CNT_W'(EXP_RST), edge_m: MARGIN_W'(MARGIN_RST),
                    space_m: MARGIN_W'(MARGIN_RST), bit_m: MARGIN_W'(MARGIN_RST),
                    final_m: MARGIN_W'(MARGIN_RST)};

    // decoder copy: measurement state, stopped with everything cleared
    logic [PHASE_W-1:0] ph_q     = PH_STOP;
    logic [CNT_W-1:0]   qual_q   = '0;
    logic [TOT_W-1:0]   edges_q  = '0;
    logic [TOT_W-1:0]   spaces_q = '0;
    logic [LOW_W-1:0]   low_q    = '0;
    logic [31:0]        high_q   = '0;

    // result words predicted for accepted samples, oldest first
    t_out_word pending_words[$];

    int  mismatch_count = 0;
    int  samples_sent   = 0;
    int  cycle_count    = 0;
    int  stall_left     = 0;
    int  hold_count     = 0;
    int  noise_pct      = 10;
    bit  src_idle       = 1'b1;
    bit  sink_idle      = 1'b1;
    bit  sink_hold      = 1'b0;

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, well above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction: one sample in, the result word it produces
    // ------------------------------------------------------------------
    function automatic t_out_word decode_sample(t_in_word w);
        t_out_word r;
        int        h;
        int        lim;
        int        n;
        logic      one;
        h = int'(w.height);
        r.done_res = 1'b0;
        if (w.abort) begin
            // abort wins over start and every phase, state is kept
            ph_q = PH_STOP;
        end else begin
            if (w.start_req) begin
                ph_q     = PH_SPACE;
                qual_q   = '0;
                edges_q  = '0;
                spaces_q = '0;
                low_q    = '0;
                high_q   = '0;
            end
            // the start sample itself is evaluated in the space phase
            case (ph_q)
                PH_SPACE: begin
                    if (h <= int'(cal.item) + int'(cal.edge_m) && qual_q != '1)
                        qual_q++;
                    if (int'(qual_q) >= int'(cal.expected)) begin
                        ph_q   = PH_EDGE;
                        qual_q = '0;
                        if (edges_q != '1)
                            edges_q++;
                    end
                end
                PH_EDGE: begin
                    if (h >= int'(cal.item) + int'(cal.space_m) && qual_q != '1)
                        qual_q++;
                    if (int'(qual_q) >= int'(cal.expected)) begin
                        // signed limit: a negative one sends every edge end to final
                        lim    = int'(cal.belt) - int'(cal.final_m);
                        ph_q   = (h <= lim) ? PH_SPACE : PH_FINAL;
                        qual_q = '0;
                        if (spaces_q != '1)
                            spaces_q++;
                        one = h > int'(cal.item) + (int'(cal.item) / 25) * 2 + int'(cal.bit_m);
                        n   = int'(spaces_q);
                        if (n >= 1 && n <= LOW_W)
                            low_q[n-1] = low_q[n-1] | one;
                        else if (n > LOW_W && n - LOW_W - 1 < HIGH_CODE_BITS)
                            high_q[n-LOW_W-1] = high_q[n-LOW_W-1] | one;
                    end
                end
                PH_FINAL: begin
                    ph_q       = PH_STOP;
                    r.done_res = 1'b1;
                end
                default: begin
                    // stopped: sample ignored
                end
            endcase
        end
        r.phase       = ph_q;
        r.low_code    = low_q;
        r.high_code   = high_q[HIGH_W-1:0];
        r.edges_seen  = edges_q;
        r.spaces_seen = spaces_q;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result side: ready with random stall bursts, long hold on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!sink_hold)
            hold_count <= 0;
        if (sink_hold && hold_count < HOLD_CYCLES) begin
            // long hold, counted here
            out_if.ready <= 1'b0;
            hold_count   <= hold_count + 1;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (sink_idle && $urandom_range(7, 0) == 0) begin
            // start a stall burst of random length
            out_if.ready <= 1'b0;
            stall_left   <= $urandom_range(12, 0);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch in %s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // every accepted result word against the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result word %h with none expected", out_if.data);
            end else begin
                want = pending_words.pop_front();
                compare_field("phase", want.phase, out_if.data.phase);
                compare_field("done_res", want.done_res, out_if.data.done_res);
                compare_field("low_code", want.low_code, out_if.data.low_code);
                compare_field("high_code", want.high_code, out_if.data.high_code);
                compare_field("edges_seen", want.edges_seen, out_if.data.edges_seen);
                compare_field("spaces_seen", want.spaces_seen, out_if.data.spaces_seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // sample side
    // ------------------------------------------------------------------

    // offer one word, hold it until taken, then maybe leave a gap
    task automatic send_word(t_in_word w);
        in_if.valid <= 1'b1;
        in_if.data  <= w;
        do @(posedge i_clk); while (!in_if.ready);
        pending_words.insert(pending_words.size(), decode_sample(w));
        samples_sent++;
        if (src_idle && $urandom_range(5, 0) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(13, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(int h, bit start, bit stop);
        t_in_word w;
        w.height    = SAMPLE_BITS'(h);
        w.start_req = start;
        w.abort     = stop;
        send_word(w);
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, int value);
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        @(posedge i_clk);
    endtask

    // write all seven registers back to back, only while idle
    task automatic load_config(t_calib c);
        i_cfg_we <= 1'b1;
        put_reg(CFG_ITEM_HEIGHT, int'(c.item));
        put_reg(CFG_BELT_HEIGHT, int'(c.belt));
        put_reg(CFG_EXPECTED, int'(c.expected));
        put_reg(CFG_EDGE_MARGIN, int'(c.edge_m));
        put_reg(CFG_SPACE_MARGIN, int'(c.space_m));
        put_reg(CFG_BIT_MARGIN, int'(c.bit_m));
        put_reg(CFG_FINAL_MARGIN, int'(c.final_m));
        i_cfg_we <= 1'b0;
        cal = c;
    endtask

    function automatic t_calib make_calib(int item, int belt, int expected,
                                          int edge_m, int space_m, int bit_m, int final_m);
        t_calib c;
        c.item     = SAMPLE_BITS'(item);
        c.belt     = SAMPLE_BITS'(belt);
        c.expected = CNT_W'(expected);
        c.edge_m   = MARGIN_W'(edge_m);
        c.space_m  = MARGIN_W'(space_m);
        c.bit_m    = MARGIN_W'(bit_m);
        c.final_m  = MARGIN_W'(final_m);
        return c;
    endfunction

    // mostly the usual value, now and then one of the extremes
    function automatic int ext_or(int max_v, int usual);
        if ($urandom_range(7, 0) != 0)
            return usual;
        return $urandom_range(1, 0) ? max_v : 0;
    endfunction

    function automatic t_calib random_calib();
        int item, belt, edge_m, space_m, bit_m, final_m, floor_v;
        item    = ext_or(MAX_HEIGHT, $urandom_range(3000, 800));
        edge_m  = ext_or(1023, $urandom_range(250, 0));
        space_m = ext_or(1023, $urandom_range(300, 20));
        bit_m   = ext_or(1023, $urandom_range(300, 0));
        final_m = ext_or(1023, $urandom_range(250, 0));
        // keep room between the one-bit level and the final limit
        floor_v = item + space_m + bit_m + final_m + 200;
        if (floor_v > MAX_HEIGHT)
            floor_v = MAX_HEIGHT;
        belt = ext_or(MAX_HEIGHT, $urandom_range(MAX_HEIGHT, floor_v));
        return make_calib(item, belt, ext_or(15, $urandom_range(4, 1)),
                          edge_m, space_m, bit_m, final_m);
    endfunction

    function automatic int pick_height(int lo, int hi);
        int a, b;
        a = (lo < 0) ? 0 : lo;
        b = (hi > MAX_HEIGHT) ? MAX_HEIGHT : hi;
        if (a > MAX_HEIGHT)
            a = MAX_HEIGHT;
        if (b < a)
            return a;
        return $urandom_range(b, a);
    endfunction

    // next sample steered by the predicted phase, with some noise mixed in
    function automatic int shape_height(bit last_bit);
        int lo, hi, zero_lvl, lim;
        zero_lvl = int'(cal.item) + (int'(cal.item) / 25) * 2 + int'(cal.bit_m);
        lim      = int'(cal.belt) - int'(cal.final_m);
        if ($urandom_range(99, 0) < noise_pct)
            return $urandom_range(MAX_HEIGHT, 0);
        case (ph_q)
            PH_SPACE: return pick_height(0, int'(cal.item) + int'(cal.edge_m));
            PH_EDGE: begin
                lo = int'(cal.item) + int'(cal.space_m);
                hi = MAX_HEIGHT;
                if (int'(qual_q) + 1 >= int'(cal.expected)) begin
                    // this sample ends the edge: pick the code bit and final or not
                    if (last_bit)
                        lo = (lo > lim + 1) ? lo : lim + 1;
                    else
                        hi = (hi < lim) ? hi : lim;
                    if ($urandom_range(1, 0))
                        lo = (lo > zero_lvl + 1) ? lo : zero_lvl + 1;
                    else
                        hi = (hi < zero_lvl) ? hi : zero_lvl;
                end
                return pick_height(lo, hi);
            end
            default: return $urandom_range(MAX_HEIGHT, 0);
        endcase
    endfunction

    // one measurement from start to done, coding n_bits bits
    task automatic run_measurement(int n_bits);
        int steps;
        send_sample(pick_height(0, int'(cal.item) + int'(cal.edge_m)), 1'b1, 1'b0);
        steps = 0;
        while (ph_q != PH_STOP && steps < 200) begin
            // rare stray start or abort breaks the sequence
            send_sample(shape_height(int'(spaces_q) + 1 >= n_bits),
                        $urandom_range(199, 0) == 0, $urandom_range(199, 0) == 0);
            steps++;
        end
        // calibration that cannot progress: give up on this one
        if (ph_q != PH_STOP)
            send_sample($urandom_range(MAX_HEIGHT, 0), 1'b0, 1'b1);
    endtask

    task automatic send_noise(int n);
        repeat (n)
            send_sample($urandom_range(MAX_HEIGHT, 0), $urandom_range(7, 0) == 0,
                        $urandom_range(7, 0) == 0);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // hand-picked walk through every phase and threshold edge
    task automatic test_directed_codes();
        wait_drain();
        // space <= 2100, edge >= 2100, one above 2260, final above 2900
        load_config(make_calib(2000, 3000, 2, 100, 100, 100, 100));
        send_sample(MAX_HEIGHT, 1'b0, 1'b0);    // stopped after reset, ignored
        send_sample(0, 1'b1, 1'b1);             // abort beats start
        send_sample(0, 1'b1, 1'b0);             // start sample counts
        send_sample(MAX_HEIGHT, 1'b0, 1'b0);    // miss does not clear the count
        send_sample(0, 1'b0, 1'b0);             // to edge
        send_sample(2100, 1'b0, 1'b0);          // edge threshold exactly
        send_sample(2099, 1'b0, 1'b0);
        send_sample(2260, 1'b0, 1'b0);          // edge end, bit 0 at the one level
        send_sample(2100, 1'b0, 1'b0);          // space threshold exactly
        send_sample(2101, 1'b0, 1'b0);
        send_sample(2100, 1'b0, 1'b0);
        send_sample(2261, 1'b0, 1'b0);
        send_sample(2900, 1'b0, 1'b0);          // bit 1, right at the final limit
        send_sample(0, 1'b0, 1'b0);
        send_sample(0, 1'b0, 1'b0);
        send_sample(MAX_HEIGHT, 1'b0, 1'b0);
        send_sample(2901, 1'b0, 1'b0);          // just past the limit: final
        send_sample(0, 1'b0, 1'b0);             // done word
        send_sample(1234, 1'b0, 1'b0);          // stopped again
        send_sample(0, 1'b1, 1'b0);
        send_sample(MAX_HEIGHT, 1'b0, 1'b1);    // abort keeps counts
        send_sample(0, 1'b0, 1'b0);
    endtask

    // zero expected count and the far ends of every register
    task automatic test_calibration_extremes();
        wait_drain();
        // negative final limit, one level never reached
        load_config(make_calib(MAX_HEIGHT, 0, 0, 1023, 1023, 1023, 1023));
        send_sample(MAX_HEIGHT, 1'b1, 1'b0);
        send_sample(MAX_HEIGHT, 1'b0, 1'b0);
        send_sample(MAX_HEIGHT, 1'b0, 1'b0);
        send_sample(MAX_HEIGHT, 1'b0, 1'b0);
        wait_drain();
        // all margins zero, longest count per phase
        load_config(make_calib(0, 4000, 15, 0, 0, 0, 0));
        noise_pct = 10;
        run_measurement(3);
    endtask

    // every sample completes a phase: totals saturate, surplus high bits drop
    task automatic test_count_saturation();
        wait_drain();
        load_config(make_calib(0, MAX_HEIGHT, 0, 0, 0, 0, 0));
        send_sample($urandom_range(MAX_HEIGHT, 0), 1'b1, 1'b0);
        repeat (520)
            send_sample($urandom_range(MAX_HEIGHT, 0), 1'b0, 1'b0);
        send_sample(0, 1'b0, 1'b1);
    endtask

    // result side held off while samples keep coming, so the input stalls
    task automatic test_sink_hold();
        wait_drain();
        load_config(make_calib(2000, 3500, 2, 100, 100, 100, 100));
        src_idle  = 1'b0;
        noise_pct = 5;
        sink_hold <= 1'b1;
        run_measurement(6);
        sink_hold <= 1'b0;
        src_idle = 1'b1;
    endtask

    // random calibrations, mostly complete measurements, some noise
    task automatic test_random_runs();
        int first;
        first = samples_sent;
        while (samples_sent - first < RANDOM_WORDS) begin
            wait_drain();
            load_config(random_calib());
            src_idle  = ($urandom_range(3, 0) != 0);
            sink_idle <= ($urandom_range(3, 0) != 0);
            noise_pct = $urandom_range(25, 0);
            repeat ($urandom_range(3, 1)) begin
                if ($urandom_range(9, 0) == 0)
                    send_noise($urandom_range(15, 4));
                else
                    run_measurement($urandom_range(12, 1));
            end
        end
    endtask

    // sender waits for a full drain mid-stream, then a gap-free finish
    task automatic test_pause_and_flush();
        wait_drain();
        src_idle  = 1'b1;
        sink_idle <= 1'b1;
        load_config(make_calib(2200, 3800, 3, 150, 120, 80, 60));
        send_noise(8);
        wait_drain();
        send_noise(8);
        wait_drain();
        src_idle  = 1'b0;
        sink_idle <= 1'b0;
        noise_pct = 10;
        run_measurement(5);
        run_measurement(9);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_ITEM_HEIGHT;
        i_cfg_data   <= '0;
        in_if.valid  <= 1'b0;
        in_if.data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_codes();
        test_calibration_extremes();
        test_count_saturation();
        test_sink_hold();
        test_random_runs();
        test_pause_and_flush();

        // all words back, then wait for anything stray
        wait_drain();
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hpcd_pkg.sv
rtl/hpcd_in_if.sv
rtl/hpcd_out_if.sv
rtl/hpcd_cfg.sv
rtl/hpcd_core.sv
rtl/height_profile_code_decoder_top.sv
verif/height_profile_code_decoder_top_test.sv
